// ===== rtl/tcce_pkg.sv =====
// Shared types and constants of the text console cursor engine.
package tcce_pkg;

  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_TAB     = 8'd9;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [7:0]  RESET_ATTR = 8'd7;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};
  localparam int          TAB_STEP   = 4;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_req_t;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_TAB,
    OP_READ,
    OP_READ_OOR
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCROLL
  } back_state_t;

endpackage

// ===== rtl/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine.
// The screen is a ROWS x COLUMNS array of 16-bit cells held in one RAM whose rows are
// rotated by a top-row pointer, so a scroll only has to blank one row. After reset the
// block runs a clearing pass over all ROWS*COLUMNS cells (2000 at the default size) with
// in_ready low; configuration writes are still taken. A request passes through the
// combinational front end into the registered queue. In the back end a put, tab, newline
// or out-of-range read goes straight to the registered output; a cell read also passes the
// registered RAM read port and the read-wait state; a put, tab or newline that scrolls first
// runs the row-blanking sweep through the single RAM write port. The back end handles one request at a time.
module text_console_cursor_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcce_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcce_pkg::out_req_t out_data
);

  logic [7:0]     color_r;
  logic [7:0]     color_nxt;
  logic           clearing;
  logic           push_valid;
  logic           push_ready;
  tcce_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  tcce_pkg::cmd_t pop_data;

  assign cfg_ready = 1'b1;
  assign color_nxt = (cfg_valid && cfg_ready) ? cfg_data : color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= tcce_pkg::RESET_ATTR;
    end else begin
      color_r <= color_nxt;
    end
  end

  tcce_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .clearing  (clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  tcce_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .text_color(color_r),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .clearing  (clearing)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("request accepted during the clearing pass");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid && !pop_ready)
    else $error("result or queue pop during the clearing pass");

  a_cursor_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.cursor_col) < COLUMNS))
    else $error("cursor column beyond the last column");

endmodule

// ===== rtl/tcce_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tcce_front.sv =====
// Front end: accepts requests and classifies them into back-end commands.
module tcce_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  tcce_pkg::in_req_t in_data,
  input  logic              clearing,
  output logic              push_valid,
  input  logic              push_ready,
  output tcce_pkg::cmd_t    push_data
);

  logic in_range;

  assign in_range = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLUMNS);

  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;

  always_comb begin
    push_data.char_code = in_data.char_code;
    push_data.row       = in_data.read_row;
    push_data.col       = in_data.read_col;
    if (in_data.func == tcce_pkg::FUNC_READ) begin
      push_data.op = in_range ? tcce_pkg::OP_READ : tcce_pkg::OP_READ_OOR;
    end else if (in_data.char_code == tcce_pkg::CH_NEWLINE) begin
      push_data.op = tcce_pkg::OP_NEWLINE;
    end else if (in_data.char_code == tcce_pkg::CH_TAB) begin
      push_data.op = tcce_pkg::OP_TAB;
    end else begin
      push_data.op = tcce_pkg::OP_PUT;
    end
  end

endmodule

// ===== rtl/tcce_queue.sv =====
// Two-entry command queue between the front end and the back end.
module tcce_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tcce_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tcce_pkg::cmd_t pop_data
);

  tcce_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     count_r;
  logic [1:0]     count_nxt;
  logic           push;
  logic           pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/tcce_back.sv =====
// Back end: cursor, screen memory with row rotation, scroll and clear sweeps.
module tcce_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         text_color,
  input  logic               q_valid,
  output logic               q_ready,
  input  tcce_pkg::cmd_t     q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcce_pkg::out_req_t out_data,
  output logic               clearing
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  tcce_pkg::back_state_t state_r;
  tcce_pkg::back_state_t state_nxt;
  logic [RW-1:0]         row_r;
  logic [RW-1:0]         row_nxt;
  logic [CW-1:0]         col_r;
  logic [CW-1:0]         col_nxt;
  logic [RW-1:0]         top_r;
  logic [RW-1:0]         top_nxt;
  logic [AW-1:0]         cnt_r;
  logic [AW-1:0]         cnt_nxt;
  logic [AW-1:0]         base_r;
  logic [AW-1:0]         base_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  tcce_pkg::out_req_t    out_data_r;
  tcce_pkg::out_req_t    out_data_nxt;

  logic                  out_free;
  logic                  take;
  logic [CW:0]           col_sum;
  logic                  wrap;
  logic                  scroll;
  logic                  clear_done;
  logic                  sweep_done;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [15:0]           mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [15:0]           mem_rdata;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr, input logic [RW-1:0] tr);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, tr};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] pr, input logic [CW-1:0] c);
    return AW'(pr) * AW'(COLUMNS) + AW'(c);
  endfunction

  assign out_free   = !out_valid_r || out_ready;
  assign take       = (state_r == tcce_pkg::ST_IDLE) && q_valid && out_free;
  assign q_ready    = take;
  assign clearing   = (state_r == tcce_pkg::ST_CLEAR);
  assign clear_done = (cnt_r == AW'(DEPTH - 1));
  assign sweep_done = (cnt_r == AW'(COLUMNS - 1));

  always_comb begin
    if (q_data.op == tcce_pkg::OP_TAB) begin
      col_sum = {1'b0, col_r} + (CW+1)'(tcce_pkg::TAB_STEP);
    end else begin
      col_sum = {1'b0, col_r} + (CW+1)'(1);
    end
    wrap   = (q_data.op == tcce_pkg::OP_NEWLINE) || (col_sum >= (CW+1)'(COLUMNS));
    scroll = wrap && (row_r == RW'(ROWS - 1));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcce_pkg::ST_CLEAR: begin
        if (clear_done) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      tcce_pkg::ST_IDLE: begin
        if (take) begin
          if (q_data.op == tcce_pkg::OP_READ) begin
            state_nxt = tcce_pkg::ST_RD_WAIT;
          end else if (q_data.op != tcce_pkg::OP_READ_OOR && scroll) begin
            state_nxt = tcce_pkg::ST_SCROLL;
          end
        end
      end
      tcce_pkg::ST_RD_WAIT: begin
        state_nxt = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_SCROLL: begin
        if (sweep_done) begin
          state_nxt = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcce_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = tcce_pkg::RESET_CELL;
    mem_raddr     = cell_addr(phys_row(RW'(q_data.row), top_r), CW'(q_data.col));
    unique case (state_r)
      tcce_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = clear_done ? '0 : cnt_r + AW'(1);
      end
      tcce_pkg::ST_IDLE: begin
        if (take) begin
          out_data_nxt.cell_value = '0;
          out_data_nxt.cursor_row = 5'(row_r);
          out_data_nxt.cursor_col = 7'(col_r);
          if (q_data.op == tcce_pkg::OP_READ_OOR) begin
            out_valid_nxt = 1'b1;
          end else if (q_data.op != tcce_pkg::OP_READ) begin
            if (q_data.op == tcce_pkg::OP_PUT) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(row_r, top_r), col_r);
              mem_wdata = {text_color, q_data.char_code};
            end
            if (wrap) begin
              col_nxt = '0;
              out_data_nxt.cursor_col = '0;
              if (scroll) begin
                top_nxt  = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
                base_nxt = cell_addr(top_r, '0);
                cnt_nxt  = '0;
              end else begin
                row_nxt = row_r + RW'(1);
                out_data_nxt.cursor_row = 5'(row_r + RW'(1));
                out_valid_nxt = 1'b1;
              end
            end else begin
              col_nxt = col_sum[CW-1:0];
              out_data_nxt.cursor_col = 7'(col_sum[CW-1:0]);
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      tcce_pkg::ST_RD_WAIT: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.cell_value = mem_rdata;
      end
      tcce_pkg::ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = base_r + cnt_r;
        mem_wdata = {text_color, tcce_pkg::CH_SPACE};
        cnt_nxt   = cnt_r + AW'(1);
        if (sweep_done) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    out_data_r <= out_data_nxt;
  end

  tcce_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
